// ----- sv/esc_pkg.sv -----
// Shared types and codes for the ESC throttle ramp with reverse arming.
// No dependencies; imported by esc_step and by the top level.
package esc_pkg;

  typedef enum logic [2:0] {
    OP_FORWARD   = 3'd0,
    OP_REVERSE   = 3'd1,
    OP_STOP      = 3'd2,
    OP_HARD_STOP = 3'd3,
    OP_STEER     = 3'd4
  } esc_op_t;

  typedef enum logic [1:0] {
    MODE_NEUTRAL     = 2'd0,
    MODE_FORWARD     = 2'd1,
    MODE_PRE_REVERSE = 2'd2,
    MODE_REVERSE     = 2'd3
  } esc_mode_t;

  typedef enum logic [2:0] {
    REG_NEUTRAL_WIDTH      = 3'd0,
    REG_REV_CREEP_WIDTH    = 3'd1,
    REG_REV_CRUISE_WIDTH   = 3'd2,
    REG_REV_FAST_WIDTH     = 3'd3,
    REG_REV_STEP           = 3'd4,
    REG_PRE_REV_STOP_WIDTH = 3'd5,
    REG_PRE_REV_HOLD_COUNT = 3'd6,
    REG_FWD_STOP_STEP      = 3'd7
  } esc_reg_t;

  localparam logic [1:0] SPEED_CREEP   = 2'd0;
  localparam logic [1:0] SPEED_CRUISE  = 2'd1;
  localparam logic [1:0] SPEED_FASTEST = 2'd2;

  localparam logic [11:0] FWD_CREEP_WIDTH   = 12'd1600;
  localparam logic [11:0] FWD_CRUISE_WIDTH  = 12'd1800;
  localparam logic [11:0] FWD_FASTEST_WIDTH = 12'd2000;
  localparam logic [11:0] RESET_WIDTH       = 12'd1500;

  typedef struct packed {
    logic [2:0]  operation;
    logic [1:0]  speed;
    logic [15:0] steer_request;
  } esc_in_t;

  typedef struct packed {
    logic [11:0] throttle_width;
    logic [9:0]  throttle_compare;
    logic [11:0] steer_width;
    logic [9:0]  steer_compare;
    logic [1:0]  drive_mode;
  } esc_out_t;

  typedef struct packed {
    logic [11:0] neutral_width;
    logic [11:0] rev_creep_width;
    logic [11:0] rev_cruise_width;
    logic [11:0] rev_fast_width;
    logic [7:0]  rev_step;
    logic [11:0] pre_rev_stop_width;
    logic [7:0]  pre_rev_hold_count;
    logic [7:0]  fwd_stop_step;
  } esc_cfg_t;

  typedef struct packed {
    esc_mode_t   mode;
    logic [11:0] throttle;
    logic [11:0] steering;
    logic [7:0]  hold_cnt;
  } esc_state_t;

endpackage

// ----- sv/esc_step.sv -----
// Next-state and result logic for one drive command.
// Depends on esc_pkg; purely combinational, used by the top level.
module esc_step import esc_pkg::*; #(
  parameter logic [7:0]  REV_STOP_STEP = 8'd10,
  parameter logic [11:0] STEER_MIN     = 12'd1000,
  parameter logic [11:0] STEER_MAX     = 12'd2000
) (
  input  esc_cfg_t   cfg,
  input  esc_state_t state,
  input  esc_in_t    cmd,
  output esc_state_t state_nxt,
  output esc_out_t   result
);

  function automatic logic [11:0] sat_sub(input logic [11:0] a, input logic [7:0] b);
    logic [11:0] bx;
    bx = {4'b0, b};
    return (a > bx) ? (a - bx) : 12'd0;
  endfunction

  function automatic logic [11:0] sat_add(input logic [11:0] a, input logic [7:0] b);
    logic [12:0] s;
    s = {1'b0, a} + {5'b0, b};
    return s[12] ? 12'hFFF : s[11:0];
  endfunction

  esc_mode_t   stop_mode;
  logic [11:0] stop_thr;
  logic [11:0] rev_target;
  logic [11:0] steer_clamped;

  // Stop behavior, shared by stop, forward with no speed and reverse in forward
  always_comb begin
    stop_mode = state.mode;
    stop_thr  = state.throttle;
    case (state.mode)
      MODE_NEUTRAL: begin
        stop_thr = cfg.neutral_width;
      end
      MODE_FORWARD: begin
        if (state.throttle > cfg.neutral_width) begin
          stop_thr = sat_sub(state.throttle, cfg.fwd_stop_step);
        end else begin
          stop_thr  = cfg.neutral_width;
          stop_mode = MODE_NEUTRAL;
        end
      end
      MODE_REVERSE: begin
        if (state.throttle < cfg.neutral_width) begin
          stop_thr = sat_add(state.throttle, REV_STOP_STEP);
        end else begin
          stop_thr  = cfg.neutral_width;
          stop_mode = MODE_NEUTRAL;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    case (cmd.speed)
      SPEED_CREEP:   rev_target = cfg.rev_creep_width;
      SPEED_CRUISE:  rev_target = cfg.rev_cruise_width;
      SPEED_FASTEST: rev_target = cfg.rev_fast_width;
      default:       rev_target = cfg.neutral_width;
    endcase
  end

  always_comb begin
    if (cmd.steer_request < {4'b0, STEER_MIN}) begin
      steer_clamped = STEER_MIN;
    end else if (cmd.steer_request > {4'b0, STEER_MAX}) begin
      steer_clamped = STEER_MAX;
    end else begin
      steer_clamped = cmd.steer_request[11:0];
    end
  end

  // Next state
  always_comb begin
    state_nxt = state;
    case (cmd.operation)
      OP_FORWARD: begin
        case (cmd.speed)
          SPEED_CREEP: begin
            state_nxt.throttle = FWD_CREEP_WIDTH;
            state_nxt.mode     = MODE_FORWARD;
          end
          SPEED_CRUISE: begin
            state_nxt.throttle = FWD_CRUISE_WIDTH;
            state_nxt.mode     = MODE_FORWARD;
          end
          SPEED_FASTEST: begin
            state_nxt.throttle = FWD_FASTEST_WIDTH;
            state_nxt.mode     = MODE_FORWARD;
          end
          default: begin
            state_nxt.throttle = stop_thr;
            state_nxt.mode     = stop_mode;
          end
        endcase
      end
      OP_REVERSE: begin
        case (state.mode)
          MODE_REVERSE: begin
            if (state.throttle > rev_target) begin
              state_nxt.throttle = sat_sub(state.throttle, cfg.rev_step);
            end else begin
              state_nxt.throttle = rev_target;
            end
          end
          MODE_FORWARD: begin
            state_nxt.throttle = stop_thr;
            state_nxt.mode     = stop_mode;
          end
          MODE_NEUTRAL: begin
            state_nxt.mode     = MODE_PRE_REVERSE;
            state_nxt.throttle = sat_sub(state.throttle, cfg.rev_step);
          end
          default: begin
            // brake ramp, then hold, then arm reverse
            if (state.throttle > cfg.pre_rev_stop_width) begin
              state_nxt.throttle = sat_sub(state.throttle, cfg.rev_step);
              state_nxt.hold_cnt = 8'd0;
            end else if (state.hold_cnt < cfg.pre_rev_hold_count) begin
              state_nxt.throttle = cfg.pre_rev_stop_width;
              state_nxt.hold_cnt = state.hold_cnt + 8'd1;
            end else begin
              state_nxt.mode     = MODE_REVERSE;
              state_nxt.throttle = cfg.neutral_width;
              state_nxt.hold_cnt = 8'd0;
            end
          end
        endcase
      end
      OP_STOP: begin
        state_nxt.throttle = stop_thr;
        state_nxt.mode     = stop_mode;
      end
      OP_HARD_STOP: begin
        state_nxt.throttle = cfg.neutral_width;
      end
      OP_STEER: begin
        state_nxt.steering = steer_clamped;
      end
      default: begin
      end
    endcase
  end

  // Result formatting
  always_comb begin
    result.throttle_width   = state_nxt.throttle;
    result.throttle_compare = state_nxt.throttle[11:2];
    result.steer_width      = state_nxt.steering;
    result.steer_compare    = state_nxt.steering[11:2];
    result.drive_mode       = state_nxt.mode;
  end

endmodule

// ----- sv/esc_throttle_ramp_with_reverse_arming_top.sv -----
// Top level of the ESC throttle ramp with reverse arming.
// Depends on esc_pkg and esc_step.
//
// Takes one drive command per cycle unless the output side stalls, and returns
// one result per command. The command lands in an input register at the
// transfer. When it advances, the drive state (mode, throttle, steering, hold
// count) updates through esc_step and the result loads into an output
// register, where it sits until taken. The state update loop sets the rate at
// one command per clock; either register stalls only when the output side
// holds back ready. Configuration writes are registered and take effect on the
// next clock, and are meant for idle periods only.
module esc_throttle_ramp_with_reverse_arming_top import esc_pkg::*; #(
  parameter logic [7:0]  REV_STOP_STEP = 8'd10,
  parameter logic [11:0] STEER_MIN     = 12'd1000,
  parameter logic [11:0] STEER_MAX     = 12'd2000
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  esc_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output esc_out_t    out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  esc_cfg_t   cfg_r;
  esc_state_t state_r;
  esc_state_t state_nxt;
  esc_in_t    in_r;
  logic       in_valid_r;
  esc_out_t   out_r;
  esc_out_t   result;
  logic       out_valid_r;
  logic       advance;

  // Move the held command into the result register when that slot frees up
  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  esc_step #(
    .REV_STOP_STEP (REV_STOP_STEP),
    .STEER_MIN     (STEER_MIN),
    .STEER_MAX     (STEER_MAX)
  ) u_step (
    .cfg       (cfg_r),
    .state     (state_r),
    .cmd       (in_r),
    .state_nxt (state_nxt),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.neutral_width      <= 12'd1500;
      cfg_r.rev_creep_width    <= 12'd1400;
      cfg_r.rev_cruise_width   <= 12'd1300;
      cfg_r.rev_fast_width     <= 12'd1200;
      cfg_r.rev_step           <= 8'd10;
      cfg_r.pre_rev_stop_width <= 12'd1300;
      cfg_r.pre_rev_hold_count <= 8'd20;
      cfg_r.fwd_stop_step      <= 8'd10;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NEUTRAL_WIDTH:      cfg_r.neutral_width      <= cfg_data;
        REG_REV_CREEP_WIDTH:    cfg_r.rev_creep_width    <= cfg_data;
        REG_REV_CRUISE_WIDTH:   cfg_r.rev_cruise_width   <= cfg_data;
        REG_REV_FAST_WIDTH:     cfg_r.rev_fast_width     <= cfg_data;
        REG_REV_STEP:           cfg_r.rev_step           <= cfg_data[7:0];
        REG_PRE_REV_STOP_WIDTH: cfg_r.pre_rev_stop_width <= cfg_data;
        REG_PRE_REV_HOLD_COUNT: cfg_r.pre_rev_hold_count <= cfg_data[7:0];
        REG_FWD_STOP_STEP:      cfg_r.fwd_stop_step      <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode     <= MODE_NEUTRAL;
      state_r.throttle <= RESET_WIDTH;
      state_r.steering <= RESET_WIDTH;
      state_r.hold_cnt <= 8'd0;
      in_valid_r       <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      if (advance) begin
        state_r <= state_nxt;
      end
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (advance) begin
      out_r <= result;
    end
  end

  // State changes only when a command moves into the result register
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(state_r))
    else $error("drive state changed without a command transfer");

  // A held command is never dropped while the result register is blocked
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !advance) |=> (in_valid_r && $stable(in_r)))
    else $error("held command lost while stalled");

  // Every processed command produces a result next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (out_valid_r && out_r.drive_mode == state_r.mode))
    else $error("processed command produced no matching result");

endmodule
